/* design/gvtf_pkg.sv */
// Package for the graph vertex topology features unit.
// Widths, sequencer states and the reciprocal table. No dependencies.
package gvtf_pkg;
	localparam int MaxVertices  = 64;
	localparam int FractionBits = 16;
	localparam int IdxW   = 6;
	localparam int CntW   = 7;
	localparam int ScoreW = 23;
	localparam int OwnW   = 22;
	localparam int NsumW  = 28;
	localparam int HopW   = 33;
	localparam int HaccW  = 36;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEG,
		ST_SCORE_ROW,
		ST_SCORE_COL,
		ST_FEAT_ROW,
		ST_FEAT_J,
		ST_FEAT_K,
		ST_EMIT,
		ST_CLEAR
	} state_t;

	localparam int RecipNum = 1 << FractionBits;
	typedef logic [FractionBits:0] recip_t;

	// floor(2^FractionBits / d), entries for d = 64 down to 0
	localparam logic [MaxVertices:0][FractionBits:0] RecipTbl = {
		recip_t'(RecipNum / 64), recip_t'(RecipNum / 63), recip_t'(RecipNum / 62),
		recip_t'(RecipNum / 61), recip_t'(RecipNum / 60), recip_t'(RecipNum / 59),
		recip_t'(RecipNum / 58), recip_t'(RecipNum / 57), recip_t'(RecipNum / 56),
		recip_t'(RecipNum / 55), recip_t'(RecipNum / 54), recip_t'(RecipNum / 53),
		recip_t'(RecipNum / 52), recip_t'(RecipNum / 51), recip_t'(RecipNum / 50),
		recip_t'(RecipNum / 49), recip_t'(RecipNum / 48), recip_t'(RecipNum / 47),
		recip_t'(RecipNum / 46), recip_t'(RecipNum / 45), recip_t'(RecipNum / 44),
		recip_t'(RecipNum / 43), recip_t'(RecipNum / 42), recip_t'(RecipNum / 41),
		recip_t'(RecipNum / 40), recip_t'(RecipNum / 39), recip_t'(RecipNum / 38),
		recip_t'(RecipNum / 37), recip_t'(RecipNum / 36), recip_t'(RecipNum / 35),
		recip_t'(RecipNum / 34), recip_t'(RecipNum / 33), recip_t'(RecipNum / 32),
		recip_t'(RecipNum / 31), recip_t'(RecipNum / 30), recip_t'(RecipNum / 29),
		recip_t'(RecipNum / 28), recip_t'(RecipNum / 27), recip_t'(RecipNum / 26),
		recip_t'(RecipNum / 25), recip_t'(RecipNum / 24), recip_t'(RecipNum / 23),
		recip_t'(RecipNum / 22), recip_t'(RecipNum / 21), recip_t'(RecipNum / 20),
		recip_t'(RecipNum / 19), recip_t'(RecipNum / 18), recip_t'(RecipNum / 17),
		recip_t'(RecipNum / 16), recip_t'(RecipNum / 15), recip_t'(RecipNum / 14),
		recip_t'(RecipNum / 13), recip_t'(RecipNum / 12), recip_t'(RecipNum / 11),
		recip_t'(RecipNum / 10), recip_t'(RecipNum / 9),  recip_t'(RecipNum / 8),
		recip_t'(RecipNum / 7),  recip_t'(RecipNum / 6),  recip_t'(RecipNum / 5),
		recip_t'(RecipNum / 4),  recip_t'(RecipNum / 3),  recip_t'(RecipNum / 2),
		recip_t'(RecipNum / 1),  recip_t'(0)
	};

	// floor(2^FractionBits / d), zero for d == 0
	function automatic recip_t recip(input logic [CntW-1:0] d);
		recip_t r;
		if (d > CntW'(MaxVertices)) r = '0;
		else r = RecipTbl[d];
		return r;
	endfunction
endpackage

/* design/graph_vertex_topology_features_unit.sv */
// Top level of the graph vertex topology features unit.
// Depends on gvtf_pkg.
//
// Use: set vertex_count through the cfg channel (cfg_valid/cfg_ready, ready
// while idle). Load adjacency rows with start while busy is low; each
// row is written to the store while start is high. A row with final_row set
// starts a run: busy stays high while the sequencer walks the store, with
// separate accumulators for the score and feature phases. Per run with n
// vertices: a degree pass, a score pass with a row read and a column walk per
// vertex, then per vertex a row read, a row walk, a two-hop walk and an emit,
// and finally a clearing pass over all 64 entries of the adjacency store.
// Each result word leaves on res_valid for exactly one cycle, last_vertex
// marks the final one. The receiver cannot stall.
// Reset returns to idle, vertex_count to 64, after a clearing pass over all
// 64 entries of the adjacency store during which busy is high.
module graph_vertex_topology_features_unit
	import gvtf_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [IdxW-1:0]      row_vertex,
	input  logic [63:0]          adjacency_row,
	input  logic                 final_row,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CntW-1:0]      cfg_data,
	output logic                 res_valid,
	output logic [IdxW-1:0]      vertex_id,
	output logic [OwnW-1:0]      own_score,
	output logic [CntW-1:0]      degree,
	output logic [NsumW-1:0]     neighbor_score_sum,
	output logic [CntW-1:0]      two_hop_count,
	output logic [HopW-1:0]      two_hop_score,
	output logic                 last_vertex
);
	state_t st_q, st_nx;
	logic [CntW-1:0] vc_q;
	logic [63:0] adj_q [MaxVertices];
	logic [CntW-1:0] deg_q [MaxVertices];
	logic [ScoreW-1:0] score_q [MaxVertices];
	logic [63:0] adj_rd_q;
	logic [CntW-1:0] deg_rd_q;
	logic [ScoreW-1:0] score_rd_q;
	logic [7:0] paths_q [MaxVertices];
	logic [IdxW-1:0] i_q, j_q;
	logic [IdxW-1:0] i_nx, j_nx;
	logic [IdxW-1:0] adj_ra, ent_ra;
	logic adj_we;
	logic [IdxW-1:0] adj_wa;
	logic [63:0] adj_wd;
	logic [63:0] row_q;
	logic [ScoreW-1:0] sacc_q;
	logic [NsumW+1:0] nacc_q;
	logic [HaccW-1:0] hacc_q;
	logic [CntW-1:0] hcnt_q;
	logic [ScoreW+7:0] hprod;
	logic [CntW-1:0] n;
	logic [63:0] colmask;
	logic [IdxW-1:0] nm1;
	logic last_j;

	assign n = (vc_q == '0) ? CntW'(1) : (vc_q > CntW'(MaxVertices)) ? CntW'(MaxVertices) : vc_q;
	assign nm1 = IdxW'(n - CntW'(1));
	assign last_j = (j_q == nm1);
	always_comb begin
		colmask = '0;
		for (int b = 0; b < 64; b++) colmask[b] = (CntW'(b) < n);
	end
	assign busy = (st_q != ST_IDLE);
	assign cfg_ready = !busy;

	always_comb begin
		st_nx = st_q;
		case (st_q)
			ST_IDLE:      if (start && final_row) st_nx = ST_DEG;
			ST_DEG:       if (last_j) st_nx = ST_SCORE_ROW;
			ST_SCORE_ROW: st_nx = ST_SCORE_COL;
			ST_SCORE_COL: if (last_j) st_nx = (i_q == nm1) ? ST_FEAT_ROW : ST_SCORE_ROW;
			ST_FEAT_ROW:  st_nx = ST_FEAT_J;
			ST_FEAT_J:    if (last_j) st_nx = ST_FEAT_K;
			ST_FEAT_K:    if (last_j) st_nx = ST_EMIT;
			ST_EMIT:      st_nx = (i_q == nm1) ? ST_CLEAR : ST_FEAT_ROW;
			ST_CLEAR:     if (j_q == IdxW'(MaxVertices-1)) st_nx = ST_IDLE;
			default:      st_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		i_nx = i_q;
		j_nx = j_q;
		case (st_q)
			ST_IDLE: begin
				i_nx = '0;
				j_nx = '0;
			end
			ST_DEG, ST_SCORE_COL, ST_FEAT_J, ST_FEAT_K: begin
				j_nx = last_j ? '0 : j_q + 1'b1;
				if (st_q == ST_SCORE_COL && last_j) i_nx = (i_q == nm1) ? '0 : i_q + 1'b1;
			end
			ST_EMIT: i_nx = (i_q == nm1) ? '0 : i_q + 1'b1;
			ST_CLEAR: j_nx = j_q + 1'b1;
			default: ;
		endcase
	end

	// stores are read at the next index through a registered read, so read data matches the current index
	assign adj_ra = (st_nx == ST_SCORE_ROW || st_nx == ST_FEAT_ROW) ? i_nx : j_nx;
	assign ent_ra = (st_nx == ST_EMIT) ? i_nx : j_nx;
	assign adj_we = (st_q == ST_CLEAR) || (st_q == ST_IDLE && start);
	assign adj_wa = (st_q == ST_CLEAR) ? j_q : row_vertex;
	assign adj_wd = (st_q == ST_CLEAR) ? '0 : adjacency_row;
	assign hprod = {8'd0, score_rd_q} * {{ScoreW{1'b0}}, paths_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			vc_q <= CntW'(MaxVertices);
			i_q <= '0;
			j_q <= '0;
			res_valid <= 1'b0;
		end else begin
			st_q <= st_nx;
			res_valid <= (st_q == ST_EMIT);
			if (cfg_valid && cfg_ready) vc_q <= cfg_data;
			i_q <= i_nx;
			j_q <= j_nx;
		end
	end

	// datapath: separate accumulators for the score and feature phases
	always_ff @(posedge clk) begin
		if (adj_we) adj_q[adj_wa] <= adj_wd;
		adj_rd_q <= (adj_we && adj_wa == adj_ra) ? adj_wd : adj_q[adj_ra];
		deg_rd_q <= deg_q[ent_ra];
		score_rd_q <= score_q[ent_ra];
		case (st_q)
			ST_DEG: deg_q[j_q] <= CntW'($countones(adj_rd_q & colmask));
			ST_SCORE_ROW: begin
				row_q <= adj_rd_q & colmask;
				sacc_q <= '0;
			end
			ST_SCORE_COL: begin
				if (row_q[j_q]) begin
					if (last_j) score_q[i_q] <= sacc_q + ScoreW'(recip(deg_rd_q));
					else sacc_q <= sacc_q + ScoreW'(recip(deg_rd_q));
				end else if (last_j) score_q[i_q] <= sacc_q;
			end
			ST_FEAT_ROW: begin
				row_q <= adj_rd_q & colmask;
				nacc_q <= '0;
				hacc_q <= '0;
				hcnt_q <= '0;
				for (int k = 0; k < MaxVertices; k++) paths_q[k] <= '0;
			end
			ST_FEAT_J: if (row_q[j_q]) begin
				nacc_q <= nacc_q + (NsumW+2)'(score_rd_q);
				for (int k = 0; k < MaxVertices; k++)
					if (adj_rd_q[k] && colmask[k]) paths_q[k] <= paths_q[k] + 8'd1;
			end
			ST_FEAT_K: begin
				if (paths_q[0] != '0 && j_q != i_q && !row_q[j_q]) begin
					hcnt_q <= hcnt_q + 1'b1;
					hacc_q <= hacc_q + {{(HaccW-ScoreW-8){1'b0}}, hprod};
				end
				for (int k = 0; k < MaxVertices - 1; k++) paths_q[k] <= paths_q[k+1];
				paths_q[MaxVertices-1] <= '0;
			end
			ST_EMIT: begin
				vertex_id <= i_q;
				degree <= deg_rd_q;
				own_score <= (score_rd_q > ScoreW'({OwnW{1'b1}})) ? '1 : OwnW'(score_rd_q);
				neighbor_score_sum <= (nacc_q > (NsumW+2)'({NsumW{1'b1}})) ? '1 : NsumW'(nacc_q);
				two_hop_count <= hcnt_q;
				two_hop_score <= (hacc_q[HaccW-1:1] > (HaccW-1)'({HopW{1'b1}})) ? '1
					: HopW'(hacc_q[HaccW-1:1]);
				last_vertex <= (i_q == nm1);
			end
			default: ;
		endcase
	end

	a_emit_one: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> busy) else $error("result outside a run");
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && last_vertex) |-> st_q == ST_CLEAR) else $error("last word misplaced");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start) || $past(st_q) == ST_IDLE) else $error("bad start");
endmodule
